/* rtl/tun_pkg.sv */
// Shared constants for the triangle unit normal pipeline.
`default_nettype none
package tun_pkg;
   localparam int unsigned M_BITS     = 31;
   localparam int unsigned SQ_BITS    = 2 * M_BITS;
   localparam int unsigned SUM_BITS   = 64;
   localparam int unsigned ROOT_STEPS = SUM_BITS / 2;
   localparam int unsigned ROOT_BITS  = SUM_BITS / 2;
   localparam int unsigned FRAC_OUT   = 14;
   localparam int unsigned Q_BITS     = FRAC_OUT + 1;
   localparam int unsigned REM_BITS   = ROOT_BITS + 1;
   localparam int unsigned OUT_BITS   = 16;
endpackage
`default_nettype wire

/* rtl/tun_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with sideband.
`default_nettype none
module tun_isqrt
   import tun_pkg::*;
#(
   parameter int unsigned SB_WIDTH = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire logic [SUM_BITS-1:0]     in_sum,
   input  wire logic [SB_WIDTH-1:0]     in_sb,
   output logic                         out_valid,
   output logic [ROOT_BITS-1:0]         out_root,
   output logic [SB_WIDTH-1:0]          out_sb
);
   logic [SUM_BITS-1:0] x_ff   [ROOT_STEPS];
   logic [SUM_BITS-1:0] res_ff [ROOT_STEPS];
   logic [SB_WIDTH-1:0] sb_ff  [ROOT_STEPS];
   logic [ROOT_STEPS-1:0] v_ff;
   logic [SUM_BITS-1:0] cur_x   [ROOT_STEPS];
   logic [SUM_BITS-1:0] cur_res [ROOT_STEPS];
   logic [SB_WIDTH-1:0] cur_sb  [ROOT_STEPS];
   logic [SUM_BITS-1:0] x_in    [ROOT_STEPS];
   logic [SUM_BITS-1:0] res_in  [ROOT_STEPS];

   always_comb begin
      cur_x[0]   = in_sum;
      cur_res[0] = '0;
      cur_sb[0]  = in_sb;
      for (int k = 1; k < ROOT_STEPS; k++) begin
         cur_x[k]   = x_ff[k-1];
         cur_res[k] = res_ff[k-1];
         cur_sb[k]  = sb_ff[k-1];
      end
   end

   always_comb begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
         logic [SUM_BITS-1:0] b;
         logic [SUM_BITS-1:0] t;
         b = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * k);
         t = cur_res[k] + b;
         if (cur_x[k] >= t) begin
            x_in[k]   = cur_x[k] - t;
            res_in[k] = (cur_res[k] >> 1) + b;
         end else begin
            x_in[k]   = cur_x[k];
            res_in[k] = cur_res[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[ROOT_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_STEPS; k++) begin
            x_ff[k]   <= x_in[k];
            res_ff[k] <= res_in[k];
            sb_ff[k]  <= cur_sb[k];
         end
      end
   end

   assign out_valid = v_ff[ROOT_STEPS-1];
   assign out_root  = res_ff[ROOT_STEPS-1][ROOT_BITS-1:0];
   assign out_sb    = sb_ff[ROOT_STEPS-1];
endmodule
`default_nettype wire

/* rtl/triangle_unit_normal.sv */
// Top level: triangle face normal, cross product scaled to unit length in Q2.14.
// Takes one item per cycle, except while a result is stalled.
// Stages: edges, products, cross, length, shift, squares, sum, 32 root steps,
// 15 divide steps (three lanes in parallel), output register.
// The whole pipeline advances together; a stalled result holds every stage.
// Reset clears the valid bits of all stages; data registers are not reset.
`default_nettype none
module triangle_unit_normal
   import tun_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_WIDTH-1:0] req_a_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_a_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_a_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_b_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_b_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_b_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_c_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_c_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_c_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [OUT_BITS-1:0]         rsp_norm_x,
   output logic signed [OUT_BITS-1:0]         rsp_norm_y,
   output logic signed [OUT_BITS-1:0]         rsp_norm_z,
   output logic                               rsp_degenerate
);
   localparam int unsigned EW  = COORD_WIDTH + 1;
   localparam int unsigned PW  = 2 * EW;
   localparam int unsigned MW  = PW;
   localparam int unsigned LW  = $clog2(MW + 1);
   localparam int unsigned SHW = MW + M_BITS;
   localparam int unsigned SBW = 1 + 3 + 3 * M_BITS;

   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // edges
   logic signed [EW-1:0] e_ff [6];
   logic v1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0] <= EW'(req_b_x) - EW'(req_a_x);
         e_ff[1] <= EW'(req_b_y) - EW'(req_a_y);
         e_ff[2] <= EW'(req_b_z) - EW'(req_a_z);
         e_ff[3] <= EW'(req_c_x) - EW'(req_a_x);
         e_ff[4] <= EW'(req_c_y) - EW'(req_a_y);
         e_ff[5] <= EW'(req_c_z) - EW'(req_a_z);
      end
   end

   // products
   logic signed [PW-1:0] p_ff [6];
   logic v2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= e_ff[1] * e_ff[5];
         p_ff[1] <= e_ff[2] * e_ff[4];
         p_ff[2] <= e_ff[2] * e_ff[3];
         p_ff[3] <= e_ff[0] * e_ff[5];
         p_ff[4] <= e_ff[0] * e_ff[4];
         p_ff[5] <= e_ff[1] * e_ff[3];
      end
   end

   // cross product as sign and magnitude
   logic signed [PW:0] n_in [3];
   logic [MW-1:0] mag_ff [3];
   logic [2:0]    neg_ff;
   logic v3_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = (PW+1)'(p_ff[2*i]) - (PW+1)'(p_ff[2*i+1]);
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= n_in[i][PW];
            mag_ff[i] <= n_in[i][PW] ? MW'(-n_in[i]) : MW'(n_in[i]);
         end
      end
   end

   // bit length of the largest magnitude
   logic [MW-1:0] orv;
   logic [LW-1:0] len_in;
   logic [LW-1:0] len_ff;
   logic [MW-1:0] mag4_ff [3];
   logic [2:0]    neg4_ff;
   logic v4_ff;
   always_comb begin
      orv    = mag_ff[0] | mag_ff[1] | mag_ff[2];
      len_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (orv[i]) len_in = LW'(i + 1);
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         len_ff  <= len_in;
         mag4_ff <= mag_ff;
         neg4_ff <= neg_ff;
      end
   end

   // common normalizing shift
   logic [M_BITS-1:0] m_in [3];
   logic [M_BITS-1:0] m_ff [3];
   logic [2:0]        neg5_ff;
   logic              deg5_ff;
   logic v5_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [SHW-1:0] w;
         w = SHW'(mag4_ff[i]);
         if (int'(len_ff) > int'(M_BITS)) begin
            w = w >> (int'(len_ff) - int'(M_BITS));
         end else begin
            w = w << (int'(M_BITS) - int'(len_ff));
         end
         m_in[i] = w[M_BITS-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m_ff    <= m_in;
         neg5_ff <= neg4_ff;
         deg5_ff <= (len_ff == '0);
      end
   end

   // squares
   logic [SQ_BITS-1:0] sq_ff [3];
   logic [M_BITS-1:0]  m6_ff [3];
   logic [2:0]         neg6_ff;
   logic               deg6_ff;
   logic v6_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQ_BITS'(m_ff[i]) * SQ_BITS'(m_ff[i]);
         end
         m6_ff   <= m_ff;
         neg6_ff <= neg5_ff;
         deg6_ff <= deg5_ff;
      end
   end

   // sum of squares
   logic [SUM_BITS-1:0] s_ff;
   logic [SBW-1:0]      sb7_ff;
   logic v7_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s_ff   <= SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
         sb7_ff <= {deg6_ff, neg6_ff, m6_ff[2], m6_ff[1], m6_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // square root
   logic                 rt_valid;
   logic [ROOT_BITS-1:0] rt_root;
   logic [SBW-1:0]       rt_sb;
   tun_isqrt #(
      .SB_WIDTH (SBW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .in_sum    (s_ff),
      .in_sb     (sb7_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_sb    (rt_sb)
   );

   // restoring division, one quotient bit per stage
   logic [REM_BITS-1:0]  rem_ff [Q_BITS][3];
   logic [Q_BITS-1:0]    q_ff   [Q_BITS][3];
   logic [ROOT_BITS-1:0] r_ff   [Q_BITS];
   logic [2:0]           dneg_ff [Q_BITS];
   logic                 ddeg_ff [Q_BITS];
   logic [Q_BITS-1:0]    dv_ff;
   logic [REM_BITS-1:0]  cur_rem [Q_BITS][3];
   logic [Q_BITS-1:0]    cur_q   [Q_BITS][3];
   logic [ROOT_BITS-1:0] cur_r   [Q_BITS];
   logic [2:0]           cur_neg [Q_BITS];
   logic                 cur_deg [Q_BITS];
   logic [REM_BITS-1:0]  rem_in  [Q_BITS][3];
   logic [Q_BITS-1:0]    q_in    [Q_BITS][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cur_rem[0][i] = REM_BITS'(rt_sb[i*M_BITS +: M_BITS]);
         cur_q[0][i]   = '0;
      end
      cur_r[0]   = rt_root;
      cur_neg[0] = rt_sb[3*M_BITS +: 3];
      cur_deg[0] = rt_sb[SBW-1];
      for (int j = 1; j < Q_BITS; j++) begin
         cur_rem[j] = rem_ff[j-1];
         cur_q[j]   = q_ff[j-1];
         cur_r[j]   = r_ff[j-1];
         cur_neg[j] = dneg_ff[j-1];
         cur_deg[j] = ddeg_ff[j-1];
      end
   end

   always_comb begin
      for (int j = 0; j < Q_BITS; j++) begin
         for (int i = 0; i < 3; i++) begin
            logic [REM_BITS-1:0] d;
            logic                hit;
            hit = cur_rem[j][i] >= REM_BITS'(cur_r[j]);
            d   = hit ? cur_rem[j][i] - REM_BITS'(cur_r[j]) : cur_rem[j][i];
            rem_in[j][i] = d << 1;
            q_in[j][i]   = {cur_q[j][i][Q_BITS-2:0], hit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (en) begin
         dv_ff <= {dv_ff[Q_BITS-2:0], rt_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < Q_BITS; j++) begin
            rem_ff[j]  <= rem_in[j];
            q_ff[j]    <= q_in[j];
            r_ff[j]    <= cur_r[j];
            dneg_ff[j] <= cur_neg[j];
            ddeg_ff[j] <= cur_deg[j];
         end
      end
   end

   // output register: sign, degenerate mask
   logic signed [OUT_BITS-1:0] norm_in [3];
   logic signed [OUT_BITS-1:0] norm_ff [3];
   logic                       deg_ff;
   logic                       rsp_valid_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [OUT_BITS-1:0] qv;
         qv = OUT_BITS'(q_ff[Q_BITS-1][i]);
         if (ddeg_ff[Q_BITS-1]) begin
            norm_in[i] = '0;
         end else if (dneg_ff[Q_BITS-1][i]) begin
            norm_in[i] = -qv;
         end else begin
            norm_in[i] = qv;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[Q_BITS-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff <= norm_in;
         deg_ff  <= ddeg_ff[Q_BITS-1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_norm_x     = norm_ff[0];
   assign rsp_norm_y     = norm_ff[1];
   assign rsp_norm_z     = norm_ff[2];
   assign rsp_degenerate = deg_ff;

   localparam logic signed [OUT_BITS-1:0] ONE_Q = OUT_BITS'(1) << FRAC_OUT;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == '0)
      else $error("degenerate result with nonzero normal");

   a_nondeg_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_norm_x != '0 || rsp_norm_y != '0 || rsp_norm_z != '0)
      else $error("normal of a proper triangle is zero");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_norm_x <= ONE_Q && rsp_norm_x >= -ONE_Q &&
         rsp_norm_y <= ONE_Q && rsp_norm_y >= -ONE_Q &&
         rsp_norm_z <= ONE_Q && rsp_norm_z >= -ONE_Q)
      else $error("normal component out of unit range");
endmodule
`default_nettype wire
